// ===== design/scl_pkg.sv =====
// Package for the serial command line parser.
// Holds the shared constants, the argument scanner control type and the
// character class helpers. No dependencies.
`timescale 1ns / 1ps

package scl_pkg;

    // Widths of the payload fields.
    localparam int BYTE_W    = 8;
    localparam int ARG_W     = 32;
    localparam int MAG_W     = 31;
    localparam int CFG_IDX_W = 2;

    // Default number of characters taken into one argument.
    localparam int ARG_CHARS_DEF = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] TERMINATOR_RST = 8'd13;
    localparam logic [BYTE_W-1:0] DELIMITER_RST  = 8'd32;

    // Largest magnitude an argument can hold.
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // Scan phases of one argument.
    localparam logic [1:0] SCAN_SKIP   = 2'd0;
    localparam logic [1:0] SCAN_DIGITS = 2'd1;
    localparam logic [1:0] SCAN_DONE   = 2'd2;

    // Control for one argument scanner.
    typedef struct packed {
        logic clear;
        logic feed;
    } t_scan_ctrl;

    // True for the bytes skipped as leading white space.
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c inside {[8'd9:8'd13], 8'd32});
    endfunction

    // True for the ASCII digits.
    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

endpackage

// ===== design/scl_arg_scan.sv =====
// Argument scanner: turns the characters of one argument into a signed value.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_arg_scan
    import scl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_scan_ctrl              i_ctrl,
    input  logic [BYTE_W-1:0]       i_char,
    output logic signed [ARG_W-1:0] o_value
);

    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [1:0]       r_phase, n_phase;

    logic             w_digit;
    logic [3:0]       w_digit_val;
    logic [MAG_W+3:0] w_acc;
    logic [MAG_W-1:0] w_mag_next;

    // Multiply by ten and add the new digit, saturating at the maximum.
    assign w_digit     = is_digit(i_char);
    assign w_digit_val = i_char[3:0];
    assign w_acc       = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                         + (MAG_W+4)'(w_digit_val);
    assign w_mag_next  = (w_acc > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : w_acc[MAG_W-1:0];

    // Scan phase handling for one incoming character.
    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_phase = r_phase;
        if (i_ctrl.clear) begin
            n_mag   = '0;
            n_neg   = 1'b0;
            n_phase = SCAN_SKIP;
        end else if (i_ctrl.feed) begin
            case (r_phase)
                SCAN_SKIP: begin
                    if (is_blank(i_char)) begin
                        n_phase = SCAN_SKIP;
                    end else if (i_char == "+" || i_char == "-") begin
                        n_neg   = (i_char == "-");
                        n_phase = SCAN_DIGITS;
                    end else if (w_digit) begin
                        n_phase = SCAN_DIGITS;
                        n_mag   = w_mag_next;
                    end else begin
                        n_phase = SCAN_DONE;
                    end
                end
                SCAN_DIGITS: begin
                    if (w_digit) begin
                        n_mag = w_mag_next;
                    end else begin
                        n_phase = SCAN_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_phase <= SCAN_SKIP;
        end else begin
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_phase <= n_phase;
        end
    end

    // Apply the sign to the magnitude.
    assign o_value = r_neg ? (ARG_W'(0) - {1'b0, r_mag}) : {1'b0, r_mag};

endmodule

// ===== design/serial_command_line_parser.sv =====
// Serial command line parser: the input register, line control and the
// result register. Depends on scl_pkg and scl_arg_scan.
//
// Usage:
// Received bytes enter on i_rx_byte with i_in_valid; a byte is taken at a
// clock edge where i_in_valid is high and o_in_stall is low. A line is a
// command letter, then up to two decimal arguments split by the delimiter
// byte. The terminator byte produces one request on the output channel with
// o_command_letter, o_first_arg and o_second_arg; all other bytes produce
// nothing. The result request is taken where o_out_valid is high and
// i_out_stall is low.
// A terminator passes through the input register and then the result
// register before it shows on the output. Throughput: one byte per cycle;
// each byte passes the input register and scanner logic. When the receiver
// stalls a waiting result, ordinary bytes still flow; only a second
// terminator waits in the input register; o_in_stall rises while it does.
// Configuration writes (terminator index 0, delimiter index 1) are always
// ready and are meant for idle periods. A synchronous reset clears the line
// state, drops any pending request and restores carriage return and space.
`timescale 1ns / 1ps

module serial_command_line_parser
    import scl_pkg::*;
#(
    parameter int ARG_CHARS = ARG_CHARS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [BYTE_W-1:0]       i_cfg_data,
    // Byte input channel.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [BYTE_W-1:0]       i_rx_byte,
    // Result channel.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [BYTE_W-1:0]       o_command_letter,
    output logic signed [ARG_W-1:0] o_first_arg,
    output logic signed [ARG_W-1:0] o_second_arg
);

    localparam int CNT_W = $clog2(ARG_CHARS + 1);

    localparam logic [1:0] FIELD_CMD  = 2'd0;
    localparam logic [1:0] FIELD_ARG1 = 2'd1;
    localparam logic [1:0] FIELD_ARG2 = 2'd2;

    logic [BYTE_W-1:0] r_term, r_delim;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic [1:0]        r_field, n_field;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_cmd;
    logic [ARG_W-1:0]  r_out_arg1, r_out_arg2;

    logic              w_out_free, w_is_term, w_process, w_emit;
    logic              w_take_char;
    t_scan_ctrl        w_ctrl1, w_ctrl2;
    logic [ARG_W-1:0]  w_arg1, w_arg2;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term  <= TERMINATOR_RST;
            r_delim <= DELIMITER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TERMINATOR: r_term  <= i_cfg_data;
                CFG_DELIMITER:  r_delim <= i_cfg_data;
                default: begin
                    r_term <= r_term;
                end
            endcase
        end
    end

    // A byte leaves the input register unless it is a terminator and the
    // result register is still held by the receiver.
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_is_term  = (r_in_byte == r_term);
    assign w_process  = r_in_vld && (!w_is_term || w_out_free);
    assign w_emit     = w_process && w_is_term;
    assign o_in_stall = r_in_vld && !w_process;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Field sequencing, command letter and argument length count.
    assign w_take_char = w_process && !w_is_term && (r_in_byte != r_delim)
                         && (r_field != FIELD_CMD) && (r_count < CNT_W'(ARG_CHARS));

    always_comb begin
        n_field = r_field;
        n_cmd   = r_cmd;
        n_count = r_count;
        if (w_emit) begin
            n_field = FIELD_CMD;
            n_cmd   = '0;
            n_count = '0;
        end else if (w_process) begin
            if (r_in_byte == r_delim) begin
                case (r_field)
                    FIELD_CMD: begin
                        n_field = FIELD_ARG1;
                        n_count = '0;
                    end
                    FIELD_ARG1: begin
                        n_field = FIELD_ARG2;
                        n_count = '0;
                    end
                    default: begin
                        n_field = r_field;
                    end
                endcase
            end else if (r_field == FIELD_CMD) begin
                n_cmd = r_in_byte;
            end else if (w_take_char) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= FIELD_CMD;
            r_cmd   <= '0;
            r_count <= '0;
        end else begin
            r_field <= n_field;
            r_cmd   <= n_cmd;
            r_count <= n_count;
        end
    end

    // Argument scanners.
    assign w_ctrl1.clear = w_emit;
    assign w_ctrl1.feed  = w_take_char && (r_field == FIELD_ARG1);
    assign w_ctrl2.clear = w_emit;
    assign w_ctrl2.feed  = w_take_char && (r_field == FIELD_ARG2);

    scl_arg_scan u_arg1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl1),
        .i_char  (r_in_byte),
        .o_value (w_arg1)
    );

    scl_arg_scan u_arg2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl2),
        .i_char  (r_in_byte),
        .o_value (w_arg2)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_cmd  <= r_cmd;
            r_out_arg1 <= w_arg1;
            r_out_arg2 <= w_arg2;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_command_letter = r_out_cmd;
    assign o_first_arg      = r_out_arg1;
    assign o_second_arg     = r_out_arg2;

endmodule

// ===== design/scl_checker.sv =====
// Port level checks for the serial command line parser, bound to the top.
// Depends on scl_pkg and serial_command_line_parser.
`timescale 1ns / 1ps

module scl_port_checker
    import scl_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [BYTE_W-1:0]       o_command_letter,
    input logic signed [ARG_W-1:0] o_first_arg,
    input logic signed [ARG_W-1:0] o_second_arg
);

    // A stalled result request stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result request keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_command_letter)
            && $stable(o_first_arg) && $stable(o_second_arg))
        else $error("result payload changed while stalled");

    // The input side only stalls while a result is held by the receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A new result needs a byte that was accepted and passed the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_rst_n, 2))
        else $error("result appeared without an accepted byte");

    // Reset leaves both channels quiet.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not quiet after reset");

endmodule

bind serial_command_line_parser scl_port_checker u_scl_checker (.*);
